/* src/dltq_pkg.sv */
// ============================================================================
// Delta-list timer queue package
// Shared types and constants for the timer queue sequencer.
// ============================================================================
package dltq_pkg;

    localparam int LAG_W    = 17;
    localparam int DELAY_W  = 16;
    localparam int ID_W     = 4;
    localparam int TAG_W    = 32;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 40;

    localparam logic [LAG_W-1:0] LAG_MAX = {LAG_W{1'b1}};

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_INIT,
        ST_WALK,
        ST_ADJ,
        ST_PLACE,
        ST_CHK,
        ST_EMIT
    } state_t;

endpackage

/* src/dltq_ram.sv */
// ============================================================================
// Generic RAM
// One write port, one read port with registered read data.
// ============================================================================
module dltq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/delta_list_timer_queue.sv */
// A start runs a restart search plus an insertion walk, one list entry a
// cycle; a tick checks the head and emits each expired timer in turn,
// stalling while m_tready is low. One transaction at a time; s_tready is
// high only when idle.
// Reset: synchronous active-low aresetn empties the list and clears all
// timers at once; no clearing pass.
// ============================================================================
// Delta-list timer queue
// One-shot timers held in expiry order, each with its lag behind the one
// before; the search and the insertion walk step through the list per cycle.
// ============================================================================
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // timer_id[3:0], delay[19:4], tag[51:20]
    input  logic                s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // expired_id[3:0], expired_tag[35:4]
    output logic                m_tlast
);

    localparam int IDX_W = $clog2(NUM_TIMERS);
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int NOW_W = LAG_W + IDX_W;

    state_t state_reg, state_next;

    logic [LAG_W-1:0] lag_reg  [NUM_TIMERS];
    logic [LAG_W-1:0] lag_next [NUM_TIMERS];
    logic [IDX_W-1:0] pid_reg  [NUM_TIMERS];
    logic [IDX_W-1:0] pid_next [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [IDX_W-1:0] id_reg, id_next;
    logic [LAG_W-1:0] d_reg, d_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [NOW_W-1:0] now_reg, now_next;
    logic [NOW_W-1:0] prev_reg, prev_next;
    logic [LAG_W-1:0] newlag_reg, newlag_next;
    logic [IDX_W-1:0] ins_reg, ins_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;

    logic [ID_W-1:0]    in_id;
    logic [DELAY_W-1:0] in_delay;
    logic [TAG_W-1:0]   in_tag;
    logic               in_id_ok;
    logic [LAG_W-1:0]   in_deff;
    logic               accept;
    logic               out_free;
    logic               tag_we;
    logic [TAG_W-1:0]   tag_rdata;
    logic [IDX_W:0]     i_plus;
    logic [LAG_W:0]     sum;

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_delay = s_tdata[ID_W+DELAY_W-1:ID_W];
    assign in_tag   = s_tdata[ID_W+DELAY_W+TAG_W-1:ID_W+DELAY_W];
    assign in_id_ok = 32'(in_id) < NUM_TIMERS;
    assign in_deff  = (in_delay == '0) ? LAG_W'(1) : LAG_W'(in_delay) + LAG_W'(1);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign tag_we   = accept && (s_tuser == OP_START) && in_id_ok;
    assign i_plus   = (IDX_W+1)'(i_reg) + (IDX_W+1)'(1);
    assign sum      = (LAG_W+1)'(lag_reg[i_reg]) + (LAG_W+1)'(lag_reg[IDX_W'(i_plus)]);

    dltq_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_TIMERS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (IDX_W'(in_id)),
        .wdata (in_tag),
        .raddr (pid_reg[0]),
        .rdata (tag_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == OP_TICK) begin
                        state_next = (count_reg == '0) ? ST_IDLE : ST_CHK;
                    end else if (!in_id_ok) begin
                        state_next = ST_IDLE;
                    end else if (active_reg[IDX_W'(in_id)]) begin
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_FIND: begin
                if (pid_reg[i_reg] == id_reg || CNT_W'(i_plus) >= count_reg) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT: begin
                if (count_reg == '0) begin
                    state_next = ST_PLACE;
                end else if (32'(count_reg) >= NUM_TIMERS) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (now_reg <= NOW_W'(d_reg) && CNT_W'(i_plus) < count_reg) begin
                    state_next = ST_WALK;
                end else if (NOW_W'(d_reg) < now_reg) begin
                    state_next = ST_ADJ;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_ADJ:   state_next = ST_PLACE;
            ST_PLACE: state_next = ST_IDLE;
            ST_CHK: begin
                state_next = (count_reg != '0 && lag_reg[0] == '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (count_reg == CNT_W'(1) || lag_reg[1] != '0)
                               ? ST_IDLE : ST_CHK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        lag_next    = lag_reg;
        pid_next    = pid_reg;
        active_next = active_reg;
        count_next  = count_reg;
        id_next     = id_reg;
        d_next      = d_reg;
        i_next      = i_reg;
        now_next    = now_reg;
        prev_next   = prev_reg;
        newlag_next = newlag_reg;
        ins_next    = ins_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    id_next = IDX_W'(in_id);
                    d_next  = in_deff;
                    i_next  = '0;
                    if (s_tuser == OP_TICK && count_reg != '0 && lag_reg[0] != '0) begin
                        lag_next[0] = lag_reg[0] - LAG_W'(1);
                    end
                end
            end
            ST_FIND: begin
                if (pid_reg[i_reg] == id_reg) begin
                    // fold the lag into the successor, then close the gap
                    for (int k = 0; k < NUM_TIMERS - 1; k++) begin
                        if (IDX_W'(k) >= i_reg) begin
                            lag_next[k] = lag_reg[k+1];
                            pid_next[k] = pid_reg[k+1];
                        end
                    end
                    if (CNT_W'(i_plus) < count_reg) begin
                        lag_next[i_reg] = sum[LAG_W] ? LAG_MAX : sum[LAG_W-1:0];
                    end
                    active_next[id_reg] = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    i_next = IDX_W'(i_plus);
                end
            end
            ST_INIT: begin
                i_next      = '0;
                prev_next   = '0;
                now_next    = NOW_W'(lag_reg[0]);
                ins_next    = '0;
                newlag_next = d_reg;
            end
            ST_WALK: begin
                if (now_reg <= NOW_W'(d_reg) && CNT_W'(i_plus) < count_reg) begin
                    prev_next = now_reg;
                    i_next    = IDX_W'(i_plus);
                    now_next  = now_reg + NOW_W'(lag_reg[IDX_W'(i_plus)]);
                end else if (NOW_W'(d_reg) < now_reg) begin
                    newlag_next = LAG_W'(NOW_W'(d_reg) - prev_reg);
                    ins_next    = i_reg;
                end else begin
                    newlag_next = LAG_W'(NOW_W'(d_reg) - now_reg);
                    ins_next    = IDX_W'(count_reg);
                end
            end
            ST_ADJ: begin
                lag_next[i_reg] = lag_reg[i_reg] - newlag_reg;
            end
            ST_PLACE: begin
                for (int k = 1; k < NUM_TIMERS; k++) begin
                    if (IDX_W'(k) > ins_reg) begin
                        lag_next[k] = lag_reg[k-1];
                        pid_next[k] = pid_reg[k-1];
                    end
                end
                lag_next[ins_reg]   = newlag_reg;
                pid_next[ins_reg]   = id_reg;
                active_next[id_reg] = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            ST_CHK: begin
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_DATA_W'({tag_rdata, ID_W'(pid_reg[0])});
                    m_last_next  = (count_reg == CNT_W'(1) || lag_reg[1] != '0);
                    // drop the head
                    for (int k = 0; k < NUM_TIMERS - 1; k++) begin
                        lag_next[k] = lag_reg[k+1];
                        pid_next[k] = pid_reg[k+1];
                    end
                    active_next[pid_reg[0]] = 1'b0;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lag_reg    <= lag_next;
        pid_reg    <= pid_next;
        id_reg     <= id_next;
        d_reg      <= d_next;
        i_reg      <= i_next;
        now_reg    <= now_next;
        prev_reg   <= prev_next;
        newlag_reg <= newlag_next;
        ins_reg    <= ins_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
